/* hdl/max_pool_2d_stream_defines.svh */
// ----------------------------------------------------------------------------
// max_pool_2d_stream_defines
// Assertion macros used by the checker file of the pooling block.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_2D_STREAM_DEFINES_SVH
`define MAX_POOL_2D_STREAM_DEFINES_SVH

// clocked property, off while in reset
`define MP2D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// stalled channel keeps its signal
`define MP2D_ASSERT_HOLD(label, vld, rdy, sig, msg) \
  `MP2D_ASSERT(label, (vld) && !(rdy) |=> $stable(sig), msg)

`endif

/* hdl/mp2d_pkg.sv */
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared widths, register map, reset values and item control flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mp2d_pkg;

  localparam int PIXEL_W    = 16;
  localparam int POOLED_W   = 15;
  localparam int SIDE_REG_W = 9;
  localparam int WIN_REG_W  = 4;
  localparam int CH_REG_W   = 11;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam int DEF_MAX_SIDE     = 256;
  localparam int DEF_MAX_WINDOW   = 8;
  localparam int DEF_MAX_CHANNELS = 1024;

  localparam logic [1:0] REG_IMAGE_SIDE = 2'd0;
  localparam logic [1:0] REG_WINDOW     = 2'd1;
  localparam logic [1:0] REG_CHANNELS   = 2'd2;

  localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 9'd4;
  localparam logic [WIN_REG_W-1:0]  WIN_RESET  = 4'd2;
  localparam logic [CH_REG_W-1:0]   CH_RESET   = 11'd1;

  typedef struct packed {
    logic active;  // pixel lies inside a whole window
    logic first;   // top-left pixel of its window
    logic emit;    // bottom-right pixel: gives a result
    logic last;    // final window of final plane
  } item_ctl_t;

endpackage

/* hdl/mp2d_cfg.sv */
// ----------------------------------------------------------------------------
// mp2d_cfg
// APB register file; gives clamped plane side, window and plane count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mp2d_cfg #(
  parameter int MAX_SIDE     = mp2d_pkg::DEF_MAX_SIDE,
  parameter int MAX_WINDOW   = mp2d_pkg::DEF_MAX_WINDOW,
  parameter int MAX_CHANNELS = mp2d_pkg::DEF_MAX_CHANNELS,
  localparam int SW  = $clog2(MAX_SIDE + 1),
  localparam int WW  = $clog2(MAX_WINDOW + 1),
  localparam int CHW = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mp2d_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mp2d_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mp2d_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic                             restart_o,
  output logic [SW-1:0]                    side_o,
  output logic [WW-1:0]                    win_o,
  output logic [CHW-1:0]                   chan_o
);
  import mp2d_pkg::*;

  localparam int SCW = (SW > SIDE_REG_W) ? SW : SIDE_REG_W;
  localparam int WCW = (WW > WIN_REG_W) ? WW : WIN_REG_W;
  localparam int CCW = (CHW > CH_REG_W) ? CHW : CH_REG_W;
  localparam int MW  = (SW > WW) ? SW : WW;

  logic [SIDE_REG_W-1:0] side_q;
  logic [WIN_REG_W-1:0]  win_q;
  logic [CH_REG_W-1:0]   chan_q;
  logic                  wr_en;
  logic [1:0]            reg_idx;
  logic [WW-1:0]         win_clamp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RESET;
      win_q  <= WIN_RESET;
      chan_q <= CH_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_IMAGE_SIDE: side_q <= pwdata[SIDE_REG_W-1:0];
        REG_WINDOW:     win_q  <= pwdata[WIN_REG_W-1:0];
        REG_CHANNELS:   chan_q <= pwdata[CH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart_o = 1'b0;
    if (wr_en) begin
      restart_o = (reg_idx == REG_IMAGE_SIDE) || (reg_idx == REG_WINDOW) ||
                  (reg_idx == REG_CHANNELS);
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_SIDE: prdata = APB_DATA_W'(side_q);
      REG_WINDOW:     prdata = APB_DATA_W'(win_q);
      REG_CHANNELS:   prdata = APB_DATA_W'(chan_q);
      default:        prdata = '0;
    endcase
  end

  // clamp into 1..MAX, window no larger than the plane
  always_comb begin
    if (side_q == '0) begin
      side_o = SW'(1);
    end else if (SCW'(side_q) > SCW'(MAX_SIDE)) begin
      side_o = SW'(MAX_SIDE);
    end else begin
      side_o = SW'(side_q);
    end

    if (win_q == '0) begin
      win_clamp = WW'(1);
    end else if (WCW'(win_q) > WCW'(MAX_WINDOW)) begin
      win_clamp = WW'(MAX_WINDOW);
    end else begin
      win_clamp = WW'(win_q);
    end

    if (MW'(win_clamp) > MW'(side_o)) begin
      win_o = WW'(side_o);
    end else begin
      win_o = win_clamp;
    end

    if (chan_q == '0) begin
      chan_o = CHW'(1);
    end else if (CCW'(chan_q) > CCW'(MAX_CHANNELS)) begin
      chan_o = CHW'(MAX_CHANNELS);
    end else begin
      chan_o = CHW'(chan_q);
    end
  end

endmodule

/* hdl/mp2d_scan.sv */
// ----------------------------------------------------------------------------
// mp2d_scan
// Raster position counters; classify each accepted pixel within its window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mp2d_scan #(
  parameter int MAX_SIDE     = mp2d_pkg::DEF_MAX_SIDE,
  parameter int MAX_WINDOW   = mp2d_pkg::DEF_MAX_WINDOW,
  parameter int MAX_CHANNELS = mp2d_pkg::DEF_MAX_CHANNELS,
  localparam int SW   = $clog2(MAX_SIDE + 1),
  localparam int WW   = $clog2(MAX_WINDOW + 1),
  localparam int CHW  = $clog2(MAX_CHANNELS + 1),
  localparam int CNTW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic                in_fire_i,
  input  logic [SW-1:0]       side_i,
  input  logic [WW-1:0]       win_i,
  input  logic [CHW-1:0]      chan_i,
  output mp2d_pkg::item_ctl_t ctl_o,
  output logic [CNTW-1:0]     oc_o
);
  import mp2d_pkg::*;

  localparam int WIW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PCW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int XW  = ((SW > WW) ? SW : WW) + 1;

  logic [CNTW-1:0] cc_q, cc_d, rc_q, rc_d, oc_q, oc_d;
  logic [WIW-1:0]  ciw_q, ciw_d, riw_q, riw_d;
  logic [PCW-1:0]  pc_q, pc_d;

  logic col_fit, row_fit, cw_end, rw_end;
  logic col_lastwin, row_lastwin, plane_last;
  logic col_end, row_end;

  always_comb begin
    col_fit = (XW'(cc_q) - XW'(ciw_q) + XW'(win_i)) <= XW'(side_i);
    row_fit = (XW'(rc_q) - XW'(riw_q) + XW'(win_i)) <= XW'(side_i);
    cw_end  = (XW'(ciw_q) + XW'(1)) == XW'(win_i);
    rw_end  = (XW'(riw_q) + XW'(1)) == XW'(win_i);
    col_lastwin = (XW'(cc_q) + XW'(1) + XW'(win_i)) > XW'(side_i);
    row_lastwin = (XW'(rc_q) + XW'(1) + XW'(win_i)) > XW'(side_i);
    plane_last  = (CHW'(pc_q) + CHW'(1)) == chan_i;
    col_end = (XW'(cc_q) + XW'(1)) >= XW'(side_i);
    row_end = (XW'(rc_q) + XW'(1)) >= XW'(side_i);

    ctl_o.active = col_fit & row_fit;
    ctl_o.first  = (ciw_q == '0) && (riw_q == '0);
    ctl_o.emit   = col_fit & row_fit & cw_end & rw_end;
    ctl_o.last   = col_lastwin & row_lastwin & plane_last;
    oc_o         = oc_q;
  end

  always_comb begin
    cc_d  = cc_q;
    rc_d  = rc_q;
    oc_d  = oc_q;
    ciw_d = ciw_q;
    riw_d = riw_q;
    pc_d  = pc_q;
    if (col_end) begin
      cc_d  = '0;
      ciw_d = '0;
      oc_d  = '0;
      if (row_end) begin
        rc_d  = '0;
        riw_d = '0;
        pc_d  = ((CHW'(pc_q) + CHW'(1)) >= chan_i) ? '0 : pc_q + PCW'(1);
      end else begin
        rc_d  = rc_q + CNTW'(1);
        riw_d = rw_end ? '0 : riw_q + WIW'(1);
      end
    end else begin
      cc_d  = cc_q + CNTW'(1);
      ciw_d = cw_end ? '0 : ciw_q + WIW'(1);
      oc_d  = cw_end ? oc_q + CNTW'(1) : oc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q  <= '0;
      rc_q  <= '0;
      oc_q  <= '0;
      ciw_q <= '0;
      riw_q <= '0;
      pc_q  <= '0;
    end else if (restart_i) begin
      cc_q  <= '0;
      rc_q  <= '0;
      oc_q  <= '0;
      ciw_q <= '0;
      riw_q <= '0;
      pc_q  <= '0;
    end else if (in_fire_i) begin
      cc_q  <= cc_d;
      rc_q  <= rc_d;
      oc_q  <= oc_d;
      ciw_q <= ciw_d;
      riw_q <= riw_d;
      pc_q  <= pc_d;
    end
  end

endmodule

/* hdl/mp2d_line.sv */
// ----------------------------------------------------------------------------
// mp2d_line
// Line store of partial maxima, compare stage and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mp2d_line #(
  parameter int MAX_SIDE = mp2d_pkg::DEF_MAX_SIDE,
  localparam int CNTW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [mp2d_pkg::PIXEL_W-1:0] pixel_i,
  input  mp2d_pkg::item_ctl_t                 ctl_i,
  input  logic [CNTW-1:0]                     oc_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mp2d_pkg::POOLED_W-1:0]       pooled_o,
  output logic                                image_done_o
);
  import mp2d_pkg::*;

  logic signed [PIXEL_W-1:0] line_mem_q [MAX_SIDE];
  logic signed [PIXEL_W-1:0] rd_q, pix_q, fwd_val_q, base, max_v;
  logic                      s1_valid_q, fwd_q, out_valid_q;
  item_ctl_t                 ctl_q;
  logic [CNTW-1:0]           oc_q;
  logic [POOLED_W-1:0]       pooled_q;
  logic                      done_q;
  logic                      out_free, s1_fire, in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!ctl_q.emit || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // entry being written this cycle is forwarded to the next item
  assign base = fwd_q ? fwd_val_q : rd_q;

  always_comb begin
    if (ctl_q.first) begin
      max_v = (pix_q > 16'sd0) ? pix_q : 16'sd0;
    end else begin
      max_v = (pix_q > base) ? pix_q : base;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && ctl_q.active) begin
      line_mem_q[oc_q] <= max_v;
    end
    if (in_fire) begin
      rd_q <= line_mem_q[oc_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pix_q     <= pixel_i;
      ctl_q     <= ctl_i;
      oc_q      <= oc_i;
      fwd_val_q <= max_v;
    end
    if (s1_fire && ctl_q.emit) begin
      pooled_q <= max_v[POOLED_W-1:0];
      done_q   <= ctl_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_fire && ctl_q.active && (oc_q == oc_i);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && ctl_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pooled_o     = pooled_q;
  assign image_done_o = done_q;

endmodule

/* hdl/max_pool_2d_stream.sv */
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Streaming non-overlapping 2D max pooling. Takes one pixel per clock,
// back to back, in raster order plane after plane. A pixel is classified by
// the position counters when accepted, its line store entry is read at the
// same edge and the pixel is held in the compare stage; from there the
// compare result is written back and, on a window's bottom-right pixel,
// loaded into the output register. The line store is a single memory, one
// write and one read per cycle; a clash between adjacent pixels is resolved
// by forwarding. Input stalls only while a result waits in the output
// register and the compare stage also holds one. No clearing pass: an entry
// is always written at a window's first pixel before it is read. Any
// register write restarts the image.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_pool_2d_stream #(
  parameter int MAX_SIDE     = mp2d_pkg::DEF_MAX_SIDE,
  parameter int MAX_WINDOW   = mp2d_pkg::DEF_MAX_WINDOW,
  parameter int MAX_CHANNELS = mp2d_pkg::DEF_MAX_CHANNELS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mp2d_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mp2d_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mp2d_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [mp2d_pkg::PIXEL_W-1:0] pixel_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mp2d_pkg::POOLED_W-1:0]       pooled_o,
  output logic                                image_done_o
);
  import mp2d_pkg::*;

  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int WW   = $clog2(MAX_WINDOW + 1);
  localparam int CHW  = $clog2(MAX_CHANNELS + 1);
  localparam int CNTW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  logic            restart;
  logic [SW-1:0]   side;
  logic [WW-1:0]   win;
  logic [CHW-1:0]  chan;
  item_ctl_t       ctl;
  logic [CNTW-1:0] oc;
  logic            in_fire;

  assign in_fire = in_valid_i & in_ready_o;

  mp2d_cfg #(
    .MAX_SIDE    (MAX_SIDE),
    .MAX_WINDOW  (MAX_WINDOW),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .restart_o(restart),
    .side_o   (side),
    .win_o    (win),
    .chan_o   (chan)
  );

  mp2d_scan #(
    .MAX_SIDE    (MAX_SIDE),
    .MAX_WINDOW  (MAX_WINDOW),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .restart_i(restart),
    .in_fire_i(in_fire),
    .side_i   (side),
    .win_i    (win),
    .chan_i   (chan),
    .ctl_o    (ctl),
    .oc_o     (oc)
  );

  mp2d_line #(
    .MAX_SIDE(MAX_SIDE)
  ) u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_i     (pixel_i),
    .ctl_i       (ctl),
    .oc_i        (oc),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pooled_o    (pooled_o),
    .image_done_o(image_done_o)
  );

endmodule

/* hdl/mp2d_checker.sv */
// ----------------------------------------------------------------------------
// mp2d_checker
// Port-level checks on the pooling block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_pool_2d_stream_defines.svh"

module mp2d_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [mp2d_pkg::POOLED_W-1:0]       pooled_o,
  input logic                                image_done_o
);

  `MP2D_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result item dropped")
  `MP2D_ASSERT_HOLD(a_out_stable, out_valid_o, out_ready_i, {pooled_o, image_done_o}, "stalled result changed")
  // empty output register never blocks the input
  `MP2D_ASSERT(a_ready_empty, !out_valid_o |-> in_ready_o, "input blocked with output empty")
  // a fresh result traces back to an accepted item, through the compare stage and the output register
  `MP2D_ASSERT(a_rise_src, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2), "result without item")

endmodule

bind max_pool_2d_stream mp2d_checker u_mp2d_checker (.*);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for max_pool_2d_stream. Pixels go in over a valid/ready
// channel with random gaps. Each accepted pixel is fed to a local model of the
// windowed maximum, and every pooled item that comes out is compared with the
// oldest prediction. Register writes over APB happen only while the block is
// drained, and each one is read back. A directed part covers the corner cases,
// then the largest sizes, a long output stall, and random traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mp2d_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 640;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned STUCK_LIMIT    = 2000;

  typedef struct packed {
    logic [POOLED_W-1:0] pooled;
    logic                done;
  } pool_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr       = '0;
  logic [APB_DATA_W-1:0]  pwdata      = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic signed [PIXEL_W-1:0] pixel_i  = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [POOLED_W-1:0]    pooled_o;
  logic                   image_done_o;

  // register mirror and pooling state
  logic [SIDE_REG_W-1:0] side_reg = SIDE_RESET;
  logic [WIN_REG_W-1:0]  win_reg  = WIN_RESET;
  logic [CH_REG_W-1:0]   chan_reg = CH_RESET;
  int unsigned col_pos, row_pos, col_in_win, row_in_win, plane_pos;
  int          line_max[DEF_MAX_SIDE];

  pool_t       expected_pools[$];
  int unsigned mismatches;
  int unsigned pools_seen;
  int unsigned stuck_cycles;
  int unsigned rx_wait;
  bit          rx_hold_req;
  bit          idling = 1'b1;

  max_pool_2d_stream dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pooled_o     (pooled_o),
    .image_done_o (image_done_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void predict_window_max(logic signed [PIXEL_W-1:0] px);
    int unsigned s, w, ch, lim, oc;
    int          v;
    pool_t       r;
    s  = eff_size(32'(side_reg), DEF_MAX_SIDE);
    w  = eff_size(32'(win_reg), DEF_MAX_WINDOW);
    ch = eff_size(32'(chan_reg), DEF_MAX_CHANNELS);
    if (w > s) w = s;
    lim = (s / w) * w;
    if (col_pos < lim && row_pos < lim) begin
      oc = (col_pos / w) % DEF_MAX_SIDE;
      if (col_in_win == 0 && row_in_win == 0) v = (px > 0) ? int'(px) : 0;
      else v = (int'(px) > line_max[oc]) ? int'(px) : line_max[oc];
      line_max[oc] = v;
      if (col_in_win + 1 == w && row_in_win + 1 == w) begin
        r.pooled = v[POOLED_W-1:0];
        r.done   = (col_pos + 1 == lim) && (row_pos + 1 == lim) && (plane_pos + 1 == ch);
        expected_pools.push_back(r);
      end
    end
    col_in_win = (col_in_win + 1 == w) ? 0 : col_in_win + 1;
    if (col_pos + 1 >= s) begin
      col_pos    = 0;
      col_in_win = 0;
      row_in_win = (row_in_win + 1 == w) ? 0 : row_in_win + 1;
      if (row_pos + 1 >= s) begin
        row_pos    = 0;
        row_in_win = 0;
        plane_pos  = (plane_pos + 1 >= ch) ? 0 : plane_pos + 1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    logic [PIXEL_W-1:0] px;
    px = PIXEL_W'($urandom());
    case ($urandom_range(0, 3))
      0: px[PIXEL_W-1] = 1'b1;
      1: px[PIXEL_W-1:8] = '0;
      default: ;
    endcase
    return px;
  endfunction

  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    int unsigned gap;
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_window_max(px);
    gap = idling ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_results_out();
    in_valid_i <= 1'b0;
    while (expected_pools.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [APB_DATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_IMAGE_SIDE: want = APB_DATA_W'(side_reg);
      REG_WINDOW:     want = APB_DATA_W'(win_reg);
      REG_CHANNELS:   want = APB_DATA_W'(chan_reg);
      default:        want = '0;
    endcase
    if (prdata !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read back %0h, expected %0h", idx, prdata, want);
    end
    @(posedge clk_i);
  endtask

  // block must be idle; any write restarts the image, line store is kept
  task automatic cfg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_IMAGE_SIDE: side_reg = value[SIDE_REG_W-1:0];
      REG_WINDOW:     win_reg  = value[WIN_REG_W-1:0];
      REG_CHANNELS:   chan_reg = value[CH_REG_W-1:0];
      default: ;
    endcase
    col_pos    = 0;
    row_pos    = 0;
    col_in_win = 0;
    row_in_win = 0;
    plane_pos  = 0;
    @(posedge clk_i);
    check_reg(idx);
  endtask

  task automatic set_geometry(input int unsigned side, input int unsigned win,
                              input int unsigned chans);
    wait_results_out();
    cfg_write(REG_IMAGE_SIDE, side);
    cfg_write(REG_WINDOW, win);
    cfg_write(REG_CHANNELS, chans);
  endtask

  // reset values, extreme pixels; image is left part done
  task automatic test_defaults();
    check_reg(REG_IMAGE_SIDE);
    check_reg(REG_WINDOW);
    check_reg(REG_CHANNELS);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'h0001);
    send_pixel(16'hFFFF);
    send_pixel(16'h8000);
    send_pixel(16'h0000);
  endtask

  // zero registers act as one; junk above each field is dropped
  task automatic test_zero_registers();
    set_geometry(32'hFFFF_FE00, 32'hFFFF_FFF0, 32'hFFFF_F800);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
  endtask

  task automatic test_window_over_plane();
    set_geometry(2, 13, 2);
    repeat (8) send_pixel(rand_pixel());
  endtask

  task automatic test_partial_windows();
    set_geometry(3, 2, 1);
    repeat (9) send_pixel(rand_pixel());
  endtask

  task automatic test_largest_sizes();
    set_geometry(DEF_MAX_SIDE, 1, 2047);
    repeat (DEF_MAX_SIDE + 4) send_pixel(rand_pixel());
    set_geometry(1, DEF_MAX_WINDOW, DEF_MAX_CHANNELS);
    repeat (40) send_pixel(rand_pixel());
  endtask

  task automatic test_output_stall();
    set_geometry(8, 1, 1);
    idling      = 1'b0;
    rx_hold_req = 1'b1;
    repeat (40) send_pixel(rand_pixel());
    wait_results_out();
    idling = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned sent, npix, whole, r, s;
    logic [APB_DATA_W-1:0] val;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_results_out();
      idling = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) begin
        val = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
        r   = $urandom_range(0, 19);
        if (r < 14)       val[SIDE_REG_W-1:0] = SIDE_REG_W'($urandom_range(1, 12));
        else if (r < 17)  val[SIDE_REG_W-1:0] = SIDE_REG_W'($urandom_range(13, 40));
        else if (r == 17) val[SIDE_REG_W-1:0] = '0;
        else if (r == 18) val[SIDE_REG_W-1:0] = SIDE_REG_W'($urandom_range(257, 511));
        else              val[SIDE_REG_W-1:0] = SIDE_REG_W'(DEF_MAX_SIDE);
        cfg_write(REG_IMAGE_SIDE, val);
      end
      if ($urandom_range(0, 2) != 0) begin
        val = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
        r   = $urandom_range(0, 9);
        if (r < 6)       val[WIN_REG_W-1:0] = WIN_REG_W'($urandom_range(1, 3));
        else if (r < 8)  val[WIN_REG_W-1:0] = WIN_REG_W'($urandom_range(4, 8));
        else if (r == 8) val[WIN_REG_W-1:0] = WIN_REG_W'($urandom_range(9, 15));
        else             val[WIN_REG_W-1:0] = '0;
        cfg_write(REG_WINDOW, val);
      end
      if ($urandom_range(0, 2) != 0) begin
        val = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
        r   = $urandom_range(0, 9);
        if (r < 6)       val[CH_REG_W-1:0] = CH_REG_W'($urandom_range(1, 3));
        else if (r == 6) val[CH_REG_W-1:0] = '0;
        else if (r == 7) val[CH_REG_W-1:0] = CH_REG_W'($urandom_range(4, 16));
        else if (r == 8) val[CH_REG_W-1:0] = CH_REG_W'($urandom_range(1024, 2047));
        else             val[CH_REG_W-1:0] = CH_REG_W'($urandom_range(17, 1023));
        cfg_write(REG_CHANNELS, val);
      end
      s     = eff_size(32'(side_reg), DEF_MAX_SIDE);
      whole = s * s * eff_size(32'(chan_reg), DEF_MAX_CHANNELS);
      if (whole <= 160 && $urandom_range(0, 4) != 0) npix = whole * $urandom_range(1, 2);
      else npix = $urandom_range(1, 120);
      repeat (npix) send_pixel(rand_pixel());
      sent += npix;
    end
  endtask

  // output side: random stalls, or one long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_wait     = RX_HOLD_CYCLES;
    end else if (rx_wait == 0 && idling && $urandom_range(0, 3) == 0) begin
      rx_wait = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    end
    if (rx_wait > 0) begin
      out_ready_i <= 1'b0;
      rx_wait--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pool_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pools.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("item %0d not expected: pooled %0d image_done %0b",
                   pools_seen, pooled_o, image_done_o);
      end else begin
        want = expected_pools.pop_front();
        if (pooled_o !== want.pooled || image_done_o !== want.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("item %0d: pooled exp %0d got %0d, image_done exp %0b got %0b",
                     pools_seen, want.pooled, pooled_o, want.done, image_done_o);
        end
      end
      pools_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_zero_registers();
    test_window_over_plane();
    test_partial_windows();
    test_largest_sizes();
    test_output_stall();
    test_random_traffic();
    wait_results_out();
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
